// ----- hw/rtl/hbr_pkg.sv -----
package hbr_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_RESIDUAL = 16'hF0B8;

    localparam logic [3:0] BYTE_BITS      = 4'd8;
    localparam logic [2:0] ONES_STUFF     = 3'd5;
    localparam logic [2:0] ONES_FLAG      = 3'd6;
    localparam logic [2:0] ONES_SAT       = 3'd7;
    localparam int unsigned MIN_REPORT    = 4;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FLAG  = 2'd1,
        KIND_ABORT = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        CFG_CLOCK_POLARITY     = 2'd0,
        CFG_ENABLE_USED        = 2'd1,
        CFG_ENABLE_ACTIVE_HIGH = 2'd2
    } cfg_index_t;

    // reflected crc-16/ccitt over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- hw/rtl/hbr_if.sv -----
interface hbr_in_if;
    logic valid;
    logic ready;
    logic clock_level;
    logic data_level;
    logic enable_level;
    logic clock_changed;

    modport source (output valid, output clock_level, output data_level,
                    output enable_level, output clock_changed, input ready);
    modport sink (input valid, input clock_level, input data_level,
                  input enable_level, input clock_changed, output ready);
endinterface

interface hbr_out_if #(
    parameter int unsigned LEN_W = 11
);
    logic             valid;
    logic             ready;
    logic [1:0]       event_kind;
    logic [7:0]       byte_value;
    logic             frame_reported;
    logic [LEN_W-1:0] frame_length;
    logic             crc_good;

    modport source (output valid, output event_kind, output byte_value,
                    output frame_reported, output frame_length, output crc_good,
                    input ready);
    modport sink (input valid, input event_kind, input byte_value,
                  input frame_reported, input frame_length, input crc_good,
                  output ready);
endinterface

interface hbr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/hdlc_bit_receiver_unit.sv -----
// a result is registered and shown in the cycle after the request that causes it
// throughput: one request per cycle, held back only while a result waits unread
// the whole bit step and byte crc update sit between the state and result registers
// reset: receive state cleared, crc at all ones, config and valid registers to their defaults
// configuration writes are always taken, one per cycle
module hdlc_bit_receiver_unit
    import hbr_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int unsigned LEN_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    hbr_in_if.sink    line,
    hbr_out_if.source report,
    hbr_cfg_if.sink   cfg
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_REPORT);

    logic clock_polarity_reg;
    logic enable_used_reg;
    logic enable_active_high_reg;

    logic [7:0]       shift_byte_reg,    shift_byte_next;
    logic [3:0]       bit_counter_reg,   bit_counter_next;
    logic [2:0]       ones_run_reg,      ones_run_next;
    logic             in_frame_reg,      in_frame_next;
    logic             flag_pending_reg,  flag_pending_next;
    logic             abort_pending_reg, abort_pending_next;
    logic [LEN_W-1:0] frame_bytes_reg,   frame_bytes_next;
    logic [15:0]      crc_reg,           crc_next;

    logic             out_valid_reg;
    event_kind_t      kind_reg,     kind_next;
    logic [7:0]       byte_reg,     byte_next;
    logic             rep_reg,      rep_next;
    logic [LEN_W-1:0] len_reg,      len_next;
    logic             good_reg,     good_next;
    logic             res_fire;

    logic step;
    logic enabled;

    assign line.ready = !out_valid_reg || report.ready;
    assign cfg.ready  = 1'b1;
    assign step       = line.valid && line.ready;
    assign enabled    = !enable_used_reg ||
                        (enable_active_high_reg ? line.enable_level : !line.enable_level);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_polarity_reg     <= 1'b1;
            enable_used_reg        <= 1'b0;
            enable_active_high_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_CLOCK_POLARITY:     clock_polarity_reg     <= cfg.data;
                CFG_ENABLE_USED:        enable_used_reg        <= cfg.data;
                CFG_ENABLE_ACTIVE_HIGH: enable_active_high_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        shift_byte_next    = shift_byte_reg;
        bit_counter_next   = bit_counter_reg;
        ones_run_next      = ones_run_reg;
        in_frame_next      = in_frame_reg;
        flag_pending_next  = flag_pending_reg;
        abort_pending_next = abort_pending_reg;
        frame_bytes_next   = frame_bytes_reg;
        crc_next           = crc_reg;
        res_fire           = 1'b0;
        kind_next          = KIND_BYTE;
        byte_next          = 8'h00;
        rep_next           = 1'b0;
        len_next           = '0;
        good_next          = 1'b0;

        if (step)
        begin
            if (!enabled)
            begin
                shift_byte_next    = 8'h00;
                bit_counter_next   = 4'd0;
                ones_run_next      = 3'd0;
                in_frame_next      = 1'b0;
                flag_pending_next  = 1'b0;
                abort_pending_next = 1'b0;
                frame_bytes_next   = '0;
                crc_next           = CRC_INIT;
            end
            else if (line.clock_changed && (line.clock_level == clock_polarity_reg))
            begin
                if (bit_counter_reg == BYTE_BITS)
                begin
                    res_fire  = 1'b1;
                    byte_next = shift_byte_reg;
                    if (frame_bytes_reg < MAX_LEN)
                    begin
                        frame_bytes_next = frame_bytes_reg + 1'b1;
                        crc_next         = crc_byte(crc_reg, shift_byte_reg);
                    end
                    shift_byte_next  = 8'h00;
                    bit_counter_next = 4'd0;
                end

                if (abort_pending_reg)
                begin
                    res_fire           = 1'b1;
                    kind_next          = KIND_ABORT;
                    byte_next          = 8'h00;
                    abort_pending_next = 1'b0;
                end

                if (flag_pending_reg)
                begin
                    res_fire          = 1'b1;
                    kind_next         = KIND_FLAG;
                    byte_next         = 8'h00;
                    rep_next          = frame_bytes_next > MIN_LEN;
                    len_next          = frame_bytes_next;
                    good_next         = rep_next && (crc_next == CRC_RESIDUAL);
                    flag_pending_next = 1'b0;
                    frame_bytes_next  = '0;
                    crc_next          = CRC_INIT;
                end

                if (line.data_level)
                begin
                    if (ones_run_reg < ONES_STUFF && in_frame_next &&
                        bit_counter_next < BYTE_BITS)
                    begin
                        shift_byte_next[bit_counter_next[2:0]] = 1'b1;
                        bit_counter_next = bit_counter_next + 1'b1;
                    end
                    if (ones_run_reg < ONES_SAT)
                        ones_run_next = ones_run_reg + 1'b1;
                end
                else
                begin
                    priority if (ones_run_reg == ONES_FLAG)
                    begin
                        in_frame_next     = 1'b1;
                        flag_pending_next = 1'b1;
                        shift_byte_next   = 8'h00;
                        bit_counter_next  = 4'd0;
                    end
                    else if (ones_run_reg > ONES_FLAG)
                    begin
                        abort_pending_next = 1'b1;
                        in_frame_next      = 1'b0;
                        shift_byte_next    = 8'h00;
                        bit_counter_next   = 4'd0;
                        frame_bytes_next   = '0;
                        crc_next           = CRC_INIT;
                    end
                    else if (ones_run_reg < ONES_STUFF)
                    begin
                        if (in_frame_next && bit_counter_next < BYTE_BITS)
                        begin
                            shift_byte_next[bit_counter_next[2:0]] = 1'b0;
                            bit_counter_next = bit_counter_next + 1'b1;
                        end
                    end
                    else
                    begin
                    end
                    ones_run_next = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg    <= 8'h00;
            bit_counter_reg   <= 4'd0;
            ones_run_reg      <= 3'd0;
            in_frame_reg      <= 1'b0;
            flag_pending_reg  <= 1'b0;
            abort_pending_reg <= 1'b0;
            frame_bytes_reg   <= '0;
            crc_reg           <= CRC_INIT;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            shift_byte_reg    <= shift_byte_next;
            bit_counter_reg   <= bit_counter_next;
            ones_run_reg      <= ones_run_next;
            in_frame_reg      <= in_frame_next;
            flag_pending_reg  <= flag_pending_next;
            abort_pending_reg <= abort_pending_next;
            frame_bytes_reg   <= frame_bytes_next;
            crc_reg           <= crc_next;
            if (res_fire)
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            rep_reg  <= rep_next;
            len_reg  <= len_next;
            good_reg <= good_next;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.event_kind     = kind_reg;
    assign report.byte_value     = byte_reg;
    assign report.frame_reported = rep_reg;
    assign report.frame_length   = len_reg;
    assign report.crc_good       = good_reg;

endmodule
